@@ hdl/svfg_pkg.sv @@
// Shared types, codes and constants of the scroll velocity frame rate governor.
// Used by the configuration, controller, datapath and top-level modules.
package svfg_pkg;

	localparam int TIME_W = 48;
	localparam int MOT_W = 24;
	localparam int SCALE_W = 24;
	localparam int BAND_W = 50;
	localparam int RATE_W = 8;
	localparam int LIM_W = 20;
	localparam int VEL_W = 37;
	localparam int NUM_W = 52;
	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W = 6;
	localparam logic [RATE_W-1:0] DEFAULT_RATE = 8'd120;
	localparam logic [31:0] US_PER_S = 32'd1000000;

	typedef enum logic [2:0] {
		KIND_START_SLIDE = 3'd0,
		KIND_STOP_SLIDE  = 3'd1,
		KIND_START_FLING = 3'd2,
		KIND_SCROLL      = 3'd3,
		KIND_FLING       = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_NA   = 2'd1,
		ST_SAME = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SC_NONE  = 2'd0,
		SC_STOP  = 2'd1,
		SC_START = 2'd2
	} scene_t;

	typedef enum logic [1:0] {
		STRAT_OFF   = 2'd0,
		STRAT_TABLE = 2'd1,
		STRAT_SCENE = 2'd2
	} strat_t;

	typedef enum logic [2:0] {
		REG_STRATEGY = 3'd0,
		REG_MM_SCALE = 3'd1,
		REG_SCROLL_0 = 3'd2,
		REG_SCROLL_1 = 3'd3,
		REG_SCROLL_2 = 3'd4,
		REG_FLING_0  = 3'd5,
		REG_FLING_1  = 3'd6,
		REG_FLING_2  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              valid;
		logic              open;
		logic [LIM_W-1:0]  max;
		logic [LIM_W-1:0]  min;
	} band_t;

	typedef struct packed {
		logic [1:0]         strategy;
		logic [SCALE_W-1:0] mm_scale;
		band_t [2:0]        scroll;
		band_t [2:0]        fling;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DT,
		OP_SQX,
		OP_SQY,
		OP_ROOT_INIT,
		OP_ROOT_STEP,
		OP_SCALE,
		OP_US,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_PICK
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    time_store;
		logic    time_clear;
		logic    rate_clear;
		logic    fling;
		logic    out_load;
		logic    from_upd;
		status_t status;
		scene_t  scene;
	} cmd_t;

	function automatic logic [RATE_W-1:0] pick_rate(input logic [VEL_W-1:0] v,
			input band_t [2:0] bands);
		logic [RATE_W-1:0] r;
		logic [VEL_W-1:0] lo;
		logic [VEL_W-1:0] hi;
		r = DEFAULT_RATE;
		for (int i = 2; i >= 0; i--) begin
			lo = {1'b0, bands[i].min, 16'b0};
			hi = {1'b0, bands[i].max, 16'b0};
			if (bands[i].valid && v >= lo && (bands[i].open || v < hi)) begin
				r = bands[i].rate;
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/svfg_cfg.sv @@
// Configuration register file of the frame rate governor.
// Depends on svfg_pkg for the register index codes and the configuration struct.
module svfg_cfg import svfg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [BAND_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STRATEGY: cfg_q.strategy <= cfg_data[1:0];
				REG_MM_SCALE: cfg_q.mm_scale <= cfg_data[SCALE_W-1:0];
				REG_SCROLL_0: cfg_q.scroll[0] <= band_t'(cfg_data);
				REG_SCROLL_1: cfg_q.scroll[1] <= band_t'(cfg_data);
				REG_SCROLL_2: cfg_q.scroll[2] <= band_t'(cfg_data);
				REG_FLING_0:  cfg_q.fling[0] <= band_t'(cfg_data);
				REG_FLING_1:  cfg_q.fling[1] <= band_t'(cfg_data);
				REG_FLING_2:  cfg_q.fling[2] <= band_t'(cfg_data);
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/svfg_ctrl.sv @@
// Controller of the frame rate governor: gesture phase, sequencing and handshakes.
// Depends on svfg_pkg; drives the datapath through cmd_t commands.
module svfg_ctrl import svfg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  kind_t item_kind,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SQX,
		S_SQY,
		S_ROOT_INIT,
		S_ROOT,
		S_SCALE,
		S_US,
		S_DIV_INIT,
		S_DIV,
		S_PICK,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic sliding_q, sliding_d;
	logic off_screen_q, off_screen_d;
	logic fling_q, fling_d;
	logic upd_q, upd_d;
	status_t res_status_q, res_status_d;
	scene_t res_scene_q, res_scene_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;
	logic enabled;
	logic scene_mode;
	logic free_out;

	assign scene_mode = (cfg.strategy == STRAT_SCENE);
	assign enabled = scene_mode || (cfg.strategy == STRAT_TABLE && |cfg.mm_scale);
	assign free_out = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		sliding_d = sliding_q;
		off_screen_d = off_screen_q;
		fling_d = fling_q;
		upd_d = upd_q;
		res_status_d = res_status_q;
		res_scene_d = res_scene_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.status = ST_NA;
		cmd.scene = SC_NONE;
		cmd.fling = fling_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_status_d = ST_NA;
				res_scene_d = SC_NONE;
				upd_d = 1'b0;
				state_d = S_FINISH;
				unique case (item_kind)
					KIND_START_SLIDE: begin
						if (enabled && !sliding_q) begin
							cmd.time_store = 1'b1;
							sliding_d = 1'b1;
							off_screen_d = 1'b0;
							res_status_d = ST_DONE;
						end
					end
					KIND_STOP_SLIDE: begin
						if (enabled && sliding_q) begin
							if (scene_mode && off_screen_q) begin
								res_scene_d = SC_STOP;
							end
							cmd.time_clear = 1'b1;
							cmd.rate_clear = 1'b1;
							sliding_d = 1'b0;
							off_screen_d = 1'b0;
							res_status_d = ST_DONE;
						end
					end
					KIND_START_FLING: begin
						if (enabled && sliding_q) begin
							if (scene_mode) begin
								res_scene_d = SC_START;
							end
							off_screen_d = 1'b1;
							res_status_d = ST_DONE;
						end
					end
					KIND_SCROLL: begin
						if (sliding_q && !off_screen_q && !scene_mode) begin
							cmd.op = OP_DT;
							cmd.time_store = 1'b1;
							fling_d = 1'b0;
							upd_d = 1'b1;
							state_d = S_SQX;
						end
					end
					KIND_FLING: begin
						if (sliding_q && off_screen_q && !scene_mode) begin
							fling_d = 1'b1;
							upd_d = 1'b1;
							state_d = S_SQX;
						end
					end
					default: begin
						res_status_d = ST_NA;
					end
				endcase
			end
			S_SQX: begin
				cmd.op = OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op = OP_SQY;
				state_d = S_ROOT_INIT;
			end
			S_ROOT_INIT: begin
				cmd.op = OP_ROOT_INIT;
				cnt_d = '0;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.op = OP_ROOT_STEP;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.op = OP_SCALE;
				state_d = fling_q ? S_PICK : S_US;
			end
			S_US: begin
				cmd.op = OP_US;
				state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.op = OP_DIV_INIT;
				cnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				cmd.op = OP_PICK;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (free_out) begin
					cmd.out_load = 1'b1;
					cmd.from_upd = upd_q;
					cmd.status = res_status_q;
					cmd.scene = res_scene_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		out_valid_d = cmd.out_load ? 1'b1 : (out_stall ? out_valid_q : 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sliding_q <= 1'b0;
			off_screen_q <= 1'b0;
			fling_q <= 1'b0;
			upd_q <= 1'b0;
			res_status_q <= ST_NA;
			res_scene_q <= SC_NONE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sliding_q <= sliding_d;
			off_screen_q <= off_screen_d;
			fling_q <= fling_d;
			upd_q <= upd_d;
			res_status_q <= res_status_d;
			res_scene_q <= res_scene_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_off_needs_slide: assert property (@(posedge clk) disable iff (!arst_n)
		off_screen_q |-> sliding_q)
		else $error("off-screen phase without an active slide");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECODE))
		else $error("accepted transaction was not decoded next cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	a_fling_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !fling_q)
		else $error("fling update entered the divider");

endmodule

@@ hdl/svfg_dp.sv @@
// Datapath of the frame rate governor: multiplier, square root, divider and band match.
// Depends on svfg_pkg; sequenced by the controller through cmd_t commands.
module svfg_dp import svfg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  cfg_t               cfg,
	input  logic [2:0]         kind,
	input  logic [TIME_W-1:0]  time_us,
	input  logic signed [MOT_W-1:0] motion_x,
	input  logic signed [MOT_W-1:0] motion_y,
	output kind_t              item_kind,
	output logic [1:0]         status,
	output logic [RATE_W-1:0]  frame_rate,
	output logic [1:0]         scene_event
);

	logic [2:0] kind_q;
	logic [TIME_W-1:0] time_q;
	logic [MOT_W-1:0] ax_q;
	logic [MOT_W-1:0] ay_q;
	logic [TIME_W-1:0] last_time_q;
	logic [RATE_W-1:0] current_rate_q;
	logic [TIME_W-1:0] dt_q;
	logic [63:0] prod_q;
	logic [47:0] acc_q;
	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [NUM_W-1:0] num_q;
	logic [TIME_W-1:0] rem_q;
	status_t upd_status_q;
	logic [RATE_W-1:0] upd_rate_q;
	status_t status_q;
	logic [RATE_W-1:0] rate_q;
	scene_t scene_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] root_t;
	logic root_ge;
	logic [TIME_W:0] div_t;
	logic div_ge;
	logic [VEL_W-1:0] vel;
	logic [RATE_W-1:0] new_rate;
	logic [47:0] sum_sq;

	assign item_kind = kind_t'(kind_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SQX: begin
				mul_a = {8'b0, ax_q};
				mul_b = {8'b0, ax_q};
			end
			OP_SQY: begin
				mul_a = {8'b0, ay_q};
				mul_b = {8'b0, ay_q};
			end
			OP_SCALE: begin
				mul_a = r_q[31:0];
				mul_b = {8'b0, cfg.mm_scale};
			end
			OP_US: begin
				mul_a = prod_q[55:24];
				mul_b = US_PER_S;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	assign sum_sq = acc_q + prod_q[47:0];
	assign root_t = r_q + bit_q;
	assign root_ge = (n_q >= root_t);
	assign div_t = {rem_q, num_q[NUM_W-1]};
	assign div_ge = (div_t >= {1'b0, dt_q});

	always_comb begin
		if (cmd.fling) begin
			vel = {{(VEL_W-32){1'b0}}, prod_q[55:24]};
		end else if (dt_q == '0 || |num_q[NUM_W-1:VEL_W]) begin
			vel = '1;
		end else begin
			vel = num_q[VEL_W-1:0];
		end
		new_rate = pick_rate(vel, cmd.fling ? cfg.fling : cfg.scroll);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			current_rate_q <= '0;
		end else begin
			if (cmd.time_clear) begin
				last_time_q <= '0;
			end else if (cmd.time_store) begin
				last_time_q <= time_q;
			end
			if (cmd.rate_clear) begin
				current_rate_q <= '0;
			end else if (cmd.op == OP_PICK && new_rate != current_rate_q) begin
				current_rate_q <= new_rate;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q <= kind;
				time_q <= time_us;
				ax_q <= motion_x[MOT_W-1] ? MOT_W'(-motion_x) : motion_x;
				ay_q <= motion_y[MOT_W-1] ? MOT_W'(-motion_y) : motion_y;
			end
			OP_DT: begin
				dt_q <= time_q - last_time_q;
			end
			OP_SQX, OP_SCALE, OP_US: begin
				prod_q <= mul_p;
			end
			OP_SQY: begin
				acc_q <= prod_q[47:0];
				prod_q <= mul_p;
			end
			OP_ROOT_INIT: begin
				n_q <= {sum_sq, 16'b0};
				r_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_ROOT_STEP: begin
				if (root_ge) begin
					n_q <= n_q - root_t;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT: begin
				num_q <= prod_q[NUM_W-1:0];
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? TIME_W'(div_t - {1'b0, dt_q}) : div_t[TIME_W-1:0];
				num_q <= {num_q[NUM_W-2:0], div_ge};
			end
			OP_PICK: begin
				if (new_rate == current_rate_q) begin
					upd_status_q <= ST_SAME;
					upd_rate_q <= '0;
				end else begin
					upd_status_q <= ST_DONE;
					upd_rate_q <= new_rate;
				end
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			status_q <= cmd.from_upd ? upd_status_q : cmd.status;
			rate_q <= cmd.from_upd ? upd_rate_q : '0;
			scene_q <= cmd.scene;
		end
	end

	assign status = status_q;
	assign frame_rate = rate_q;
	assign scene_event = scene_q;

endmodule

@@ hdl/scroll_velocity_frame_rate_governor.sv @@
// Top level of the scroll velocity frame rate governor.
// Depends on svfg_pkg and instantiates svfg_cfg, svfg_ctrl and svfg_dp.
//
// One transaction is processed at a time, and a finished result waits in an
// output register so the next transaction can be taken while it is stalled.
// Start slide, stop slide, start fling, unknown kinds and updates that do not
// apply go from decode straight to finish. A fling update skips microsecond
// scaling and time step division, which a scroll update runs. The magnitude
// square root runs one result bit per cycle, the shared 32x32 multiplier is
// used once per product, and the time step division runs one quotient bit
// per cycle. The input is stalled from acceptance until the result is loaded.
module scroll_velocity_frame_rate_governor import svfg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              kind,
	input  logic [TIME_W-1:0]       time_us,
	input  logic signed [MOT_W-1:0] motion_x,
	input  logic signed [MOT_W-1:0] motion_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [RATE_W-1:0]       frame_rate,
	output logic [1:0]              scene_event,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [BAND_W-1:0]       cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	kind_t item_kind;

	svfg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	svfg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_kind (item_kind),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	svfg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.kind        (kind),
		.time_us     (time_us),
		.motion_x    (motion_x),
		.motion_y    (motion_y),
		.item_kind   (item_kind),
		.status      (status),
		.frame_rate  (frame_rate),
		.scene_event (scene_event)
	);

endmodule
